/* design/sctc_pkg.sv */
// Shared types and constants of the sector cache tag controller.
// Depends on nothing; the tag memory, the sequencer and the top level refer to it by scoped names.
package sctc_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_ACCESS     = 2'd0,
    OP_MARK_DIRTY = 2'd1,
    OP_FLUSH      = 2'd2,
    OP_FAIL       = 2'd3
  } opcode_e;

  // Kinds of result transaction.
  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_COPIES = 2'd2;

  localparam logic [31:0] TAG_INVALID  = 32'hFFFF_FFFF;
  localparam logic [7:0]  AGE_MAX      = 8'd255;
  localparam logic [2:0]  COPIES_RESET = 3'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] req_sector;
    logic        is_write;
    logic [2:0]  entry_index;
    logic        fail_in_flush;
  } req_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cmd_sector;
    logic [2:0]  buffer_slot;
    logic        was_hit;
    logic        last;
  } rsp_t;

  // One word of the tag memory.
  typedef struct packed {
    logic [31:0] tag;
    logic        dirty;
    logic [7:0]  age;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{tag: TAG_INVALID, dirty: 1'b0, age: AGE_MAX};

  // Mirroring settings derived from the configuration registers.
  typedef struct packed {
    logic [31:0] fat_length;
    logic [31:0] fat_start;
    logic [32:0] fat_end;
    logic [1:0]  mirror_cnt;
  } cfg_t;

endpackage

/* design/sctc_stream_if.sv */
// Valid/ready channel carrying one payload per transaction.
// The payload type is a parameter; the design uses the structs of sctc_pkg.
interface sctc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/sctc_tag_ram.sv */
// Tag memory of the cache: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as the reset word of sctc_pkg.
module sctc_tag_ram #(
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  sctc_pkg::entry_t wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output sctc_pkg::entry_t rd_data_o
);

  sctc_pkg::entry_t mem_q [DEPTH];
  sctc_pkg::entry_t rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  // Storage array and read data register.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits are cleared at reset and set by the first write of an entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : sctc_pkg::ENTRY_RESET;

endmodule

/* design/sctc_seq.sv */
// Sequencer: walks the tag memory with read-modify-write and emits results.
// Uses sctc_pkg types and the sctc_stream_if channels; drives sctc_tag_ram.
module sctc_seq #(
  parameter int unsigned CACHE_ENTRIES = 4,
  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sctc_pkg::cfg_t      cfg_i,
  sctc_stream_if.sink         req,
  sctc_stream_if.source       rsp,
  output logic                ram_wr_en_o,
  output logic [IDX_W-1:0]    ram_wr_addr_o,
  output sctc_pkg::entry_t    ram_wr_data_o,
  output logic                ram_rd_en_o,
  output logic [IDX_W-1:0]    ram_rd_addr_o,
  input  sctc_pkg::entry_t    ram_rd_data_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AWALK  = 4'd1;
  localparam logic [3:0] S_AFIN   = 4'd2;
  localparam logic [3:0] S_WB     = 4'd3;
  localparam logic [3:0] S_MIR    = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_ANSWER = 4'd6;
  localparam logic [3:0] S_FCHK   = 4'd7;
  localparam logic [3:0] S_FNEXT  = 4'd8;
  localparam logic [3:0] S_RMW    = 4'd9;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        op_q, op_d;
  logic [31:0]       sec_q, sec_d;
  logic              wr_q, wr_d;
  logic [2:0]        idx_q, idx_d;
  logic              fif_q, fif_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hsel_q, hsel_d;
  logic              hdirty_q, hdirty_d;
  logic [IDX_W-1:0]  vsel_q, vsel_d;
  logic [7:0]        best_q, best_d;
  logic [31:0]       vtag_q, vtag_d;
  logic              vdirty_q, vdirty_d;
  logic [IDX_W-1:0]  sel_q, sel_d;
  logic [31:0]       wb_sec_q, wb_sec_d;
  logic [IDX_W-1:0]  wb_slot_q, wb_slot_d;
  logic [1:0]        mir_q, mir_d;
  logic              out_vld_q, out_vld_d;
  sctc_pkg::rsp_t    out_data_q, out_data_d;

  sctc_pkg::entry_t  rd;
  sctc_pkg::entry_t  wdata;
  sctc_pkg::rsp_t    answer;
  logic [7:0]        aged;
  logic              load_ok;
  logic              load;
  logic              in_fat;
  logic              idx_ok;
  logic [3:0]        ret_state;

  assign rd      = ram_rd_data_i;
  assign aged    = (rd.age == sctc_pkg::AGE_MAX) ? sctc_pkg::AGE_MAX : rd.age + 8'd1;
  assign load_ok = !out_vld_q || rsp.ready;
  assign idx_ok  = ({1'b0, req.data.entry_index} < 4'(CACHE_ENTRIES));

  // A written-back sector lies in the primary FAT when start <= sector < end.
  assign in_fat = (cfg_i.fat_length != 32'd0) && (wb_sec_q >= cfg_i.fat_start) &&
                  ({1'b0, wb_sec_q} < cfg_i.fat_end);

  // Where a write-back sequence continues once its last command has gone.
  always_comb begin
    if (op_q == sctc_pkg::OP_FLUSH) begin
      ret_state = S_FNEXT;
    end else if (wr_q) begin
      ret_state = S_ANSWER;
    end else begin
      ret_state = S_READ;
    end
  end

  // Final answer or acknowledge of the current operation.
  always_comb begin
    answer = '{kind: sctc_pkg::KIND_ANSWER, cmd_sector: 32'd0, buffer_slot: idx_q,
               was_hit: 1'b0, last: 1'b1};
    if (op_q == sctc_pkg::OP_ACCESS) begin
      answer.cmd_sector  = sec_q;
      answer.buffer_slot = 3'(sel_q);
      answer.was_hit     = hit_q;
    end else if (op_q == sctc_pkg::OP_FLUSH) begin
      answer.buffer_slot = 3'd0;
    end
  end

  // Main sequencer.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    sec_d      = sec_q;
    wr_d       = wr_q;
    idx_d      = idx_q;
    fif_d      = fif_q;
    hit_d      = hit_q;
    hsel_d     = hsel_q;
    hdirty_d   = hdirty_q;
    vsel_d     = vsel_q;
    best_d     = best_q;
    vtag_d     = vtag_q;
    vdirty_d   = vdirty_q;
    sel_d      = sel_q;
    wb_sec_d   = wb_sec_q;
    wb_slot_d  = wb_slot_q;
    mir_d      = mir_q;
    out_data_d = out_data_q;
    load       = 1'b0;
    wdata      = rd;

    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = cnt_q;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = cnt_q;
    req.ready     = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d     = req.data.opcode;
          sec_d    = req.data.req_sector;
          wr_d     = req.data.is_write;
          idx_d    = req.data.entry_index;
          fif_d    = req.data.fail_in_flush;
          hit_d    = 1'b0;
          hsel_d   = '0;
          vsel_d   = '0;
          best_d   = 8'd0;
          cnt_d    = '0;
          if (req.data.opcode == sctc_pkg::OP_ACCESS) begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = '0;
            state_d       = S_AWALK;
          end else if (req.data.opcode == sctc_pkg::OP_FLUSH) begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = '0;
            state_d       = S_FCHK;
          end else if (idx_ok) begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = req.data.entry_index[IDX_W-1:0];
            state_d       = S_RMW;
          end else begin
            state_d = S_ANSWER;
          end
        end
      end

      // Age each entry, look for the first hit and the first oldest entry.
      S_AWALK: begin
        ram_wr_en_o = 1'b1;
        wdata.age   = aged;
        if (!hit_q && (rd.tag == sec_q)) begin
          hit_d    = 1'b1;
          hsel_d   = cnt_q;
          hdirty_d = rd.dirty;
        end
        if (aged > best_q) begin
          best_d   = aged;
          vsel_d   = cnt_q;
          vtag_d   = rd.tag;
          vdirty_d = rd.dirty;
        end
        if (cnt_q == LAST_IDX) begin
          state_d = S_AFIN;
        end else begin
          cnt_d         = cnt_q + 1'b1;
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = cnt_q + 1'b1;
        end
      end

      // Update the selected entry and decide which commands follow.
      S_AFIN: begin
        ram_wr_en_o = 1'b1;
        wdata.tag   = sec_q;
        wdata.age   = 8'd0;
        if (hit_q) begin
          ram_wr_addr_o = hsel_q;
          wdata.dirty   = hdirty_q;
          sel_d         = hsel_q;
          state_d       = S_ANSWER;
        end else begin
          ram_wr_addr_o = vsel_q;
          wdata.dirty   = wr_q;
          sel_d         = vsel_q;
          if (vdirty_q) begin
            wb_sec_d  = vtag_q;
            wb_slot_d = vsel_q;
            state_d   = S_WB;
          end else begin
            state_d = ret_state;
          end
        end
      end

      // Write-back command of the entry's own sector.
      S_WB: begin
        if (load_ok) begin
          load       = 1'b1;
          out_data_d = '{kind: sctc_pkg::KIND_WRITE, cmd_sector: wb_sec_q,
                         buffer_slot: 3'(wb_slot_q), was_hit: 1'b0, last: 1'b0};
          wb_sec_d   = wb_sec_q + cfg_i.fat_length;
          if (in_fat && (cfg_i.mirror_cnt != 2'd0)) begin
            mir_d   = cfg_i.mirror_cnt;
            state_d = S_MIR;
          end else begin
            state_d = ret_state;
          end
        end
      end

      // Mirror writes into the further FAT copies.
      S_MIR: begin
        if (load_ok) begin
          load       = 1'b1;
          out_data_d = '{kind: sctc_pkg::KIND_WRITE, cmd_sector: wb_sec_q,
                         buffer_slot: 3'(wb_slot_q), was_hit: 1'b0, last: 1'b0};
          wb_sec_d   = wb_sec_q + cfg_i.fat_length;
          mir_d      = mir_q - 2'd1;
          if (mir_q == 2'd1) begin
            state_d = ret_state;
          end
        end
      end

      S_READ: begin
        if (load_ok) begin
          load       = 1'b1;
          out_data_d = '{kind: sctc_pkg::KIND_READ, cmd_sector: sec_q,
                         buffer_slot: 3'(sel_q), was_hit: 1'b0, last: 1'b0};
          state_d    = S_ANSWER;
        end
      end

      S_ANSWER: begin
        if (load_ok) begin
          load       = 1'b1;
          out_data_d = answer;
          state_d    = S_IDLE;
        end
      end

      // Flush: clear age and dirty mark, write back when the entry was dirty.
      S_FCHK: begin
        ram_wr_en_o = 1'b1;
        wdata.dirty = 1'b0;
        wdata.age   = 8'd0;
        if (rd.dirty) begin
          wb_sec_d  = rd.tag;
          wb_slot_d = cnt_q;
          state_d   = S_WB;
        end else begin
          state_d = S_FNEXT;
        end
      end

      S_FNEXT: begin
        if (cnt_q == LAST_IDX) begin
          state_d = S_ANSWER;
        end else begin
          cnt_d         = cnt_q + 1'b1;
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = cnt_q + 1'b1;
          state_d       = S_FCHK;
        end
      end

      // Mark dirty or failure report on one entry.
      S_RMW: begin
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = idx_q[IDX_W-1:0];
        if ((op_q == sctc_pkg::OP_FAIL) && !fif_q) begin
          wdata.tag   = sctc_pkg::TAG_INVALID;
          wdata.dirty = 1'b0;
        end else begin
          wdata.dirty = 1'b1;
        end
        state_d = S_ANSWER;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_wr_data_o = wdata;

  // Output register: it empties when taken and reloads in the same cycle.
  always_comb begin
    if (load) begin
      out_vld_d = 1'b1;
    end else if (rsp.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign rsp.valid = out_vld_q;
  assign rsp.data  = out_data_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Operation context and result payload.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sec_q      <= sec_d;
    wr_q       <= wr_d;
    idx_q      <= idx_d;
    fif_q      <= fif_d;
    hit_q      <= hit_d;
    hsel_q     <= hsel_d;
    hdirty_q   <= hdirty_d;
    vsel_q     <= vsel_d;
    best_q     <= best_d;
    vtag_q     <= vtag_d;
    vdirty_q   <= vdirty_d;
    sel_q      <= sel_d;
    wb_sec_q   <= wb_sec_d;
    wb_slot_q  <= wb_slot_d;
    mir_q      <= mir_d;
    out_data_q <= out_data_d;
  end

endmodule

/* design/sector_cache_tag_controller.sv */
// Sector cache tag controller. An access walks the tag memory, one entry per cycle on
// its single read port, then issues any write-back, mirror or read commands and its
// answer. A flush walks every entry and issues write-back and mirror commands for each
// dirty one; mark dirty and failure reports update one entry, or only answer when the
// index lies past the last entry. One operation is in flight at a time. Reset
// (asynchronous, active low) marks every entry invalid, clean and of age 255 at once;
// no clearing pass.
module sector_cache_tag_controller #(
  parameter int unsigned CACHE_ENTRIES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sctc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i,
  sctc_stream_if.sink                       req,
  sctc_stream_if.source                     rsp
);

  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);

  logic [31:0]       fat_length_q;
  logic [31:0]       fat_start_q;
  logic [2:0]        fat_copies_q;
  logic [32:0]       fat_end_q;
  logic [1:0]        mirror_cnt_q, mirror_cnt_d;
  sctc_pkg::cfg_t    cfg;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  sctc_pkg::entry_t  ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  sctc_pkg::entry_t  ram_rd_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_length_q <= 32'd0;
      fat_start_q  <= 32'd0;
      fat_copies_q <= sctc_pkg::COPIES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sctc_pkg::CFG_FAT_LENGTH: fat_length_q <= cfg_wdata_i;
        sctc_pkg::CFG_FAT_START:  fat_start_q  <= cfg_wdata_i;
        sctc_pkg::CFG_FAT_COPIES: fat_copies_q <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // Number of mirror copies: zero counts as one copy, anything above four as four.
  always_comb begin
    if (fat_copies_q inside {3'd0, 3'd1}) begin
      mirror_cnt_d = 2'd0;
    end else if (fat_copies_q inside {[3'd4:3'd7]}) begin
      mirror_cnt_d = 2'd3;
    end else begin
      mirror_cnt_d = 2'(fat_copies_q - 3'd1);
    end
  end

  // End of the primary FAT and the mirror count, held ready for the sequencer.
  always_ff @(posedge clk_i) begin
    fat_end_q    <= {1'b0, fat_start_q} + {1'b0, fat_length_q};
    mirror_cnt_q <= mirror_cnt_d;
  end

  assign cfg = '{fat_length: fat_length_q, fat_start: fat_start_q,
                 fat_end: fat_end_q, mirror_cnt: mirror_cnt_q};

  sctc_tag_ram #(
    .DEPTH (CACHE_ENTRIES)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  sctc_seq #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .req           (req),
    .rsp           (rsp),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

endmodule
